// ===== design/cplg_pkg.sv =====
// ----------------------------------------------------------------------------
// cplg_pkg
// Shared types and constants of the chassis power-limit gain block.
// ----------------------------------------------------------------------------
package cplg_pkg;

	localparam int GainFracBits = 15;
	localparam int OfflineTicks = 250;

	localparam int DivWidth = 32;
	localparam int DvsWidth = 16;
	localparam int MulWidth = 16;

	localparam logic [15:0] Q_ONE      = 16'd32768;
	localparam logic [15:0] Q_CAP_MIN  = 16'd1638;
	localparam logic [15:0] Q_OVF_STEP = 16'd983;
	localparam logic [15:0] Q_OVF_MIN  = 16'd22938;
	localparam logic [15:0] Q_BUF_MAX  = 16'd13107;
	localparam logic [15:0] Q_FALLBACK = 16'd3277;

	localparam logic [1:0] REQ_CAP     = 2'd0;
	localparam logic [1:0] REQ_REFEREE = 2'd1;
	localparam logic [1:0] REQ_TICK    = 2'd2;
	localparam logic [1:0] REQ_CONTROL = 2'd3;

	typedef struct packed {
		logic                start;
		logic [DivWidth-1:0] dividend;
		logic [DvsWidth-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  start;
		logic [MulWidth-1:0]   a;
		logic [MulWidth-1:0]   b;
	} mul_req_t;

endpackage

// ===== design/cplg_div.sv =====
// ----------------------------------------------------------------------------
// cplg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cplg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cplg_pkg::div_req_t            req,
	output logic                          done,
	output logic [cplg_pkg::DivWidth-1:0] quotient
);

	logic [cplg_pkg::DivWidth-1:0] work_q;
	logic [cplg_pkg::DvsWidth-1:0] dvs_q;
	logic [cplg_pkg::DvsWidth:0]   rem_q;
	logic [5:0]                    cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [cplg_pkg::DvsWidth:0]   rem_sh;
	logic                          fits;

	assign rem_sh = {rem_q[cplg_pkg::DvsWidth-1:0], work_q[cplg_pkg::DivWidth-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(cplg_pkg::DivWidth - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			dvs_q  <= req.divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			work_q <= {work_q[cplg_pkg::DivWidth-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

// ===== design/cplg_mul.sv =====
// ----------------------------------------------------------------------------
// cplg_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cplg_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cplg_pkg::mul_req_t              req,
	output logic                            done,
	output logic [2*cplg_pkg::MulWidth-1:0] product
);

	logic [2*cplg_pkg::MulWidth-1:0] mcand_q;
	logic [2*cplg_pkg::MulWidth-1:0] acc_q;
	logic [cplg_pkg::MulWidth-1:0]   mplier_q;
	logic [4:0]                      cnt_q;
	logic                            busy_q;
	logic                            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(cplg_pkg::MulWidth - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= {{cplg_pkg::MulWidth{1'b0}}, req.a};
			mplier_q <= req.b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[2*cplg_pkg::MulWidth-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[cplg_pkg::MulWidth-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== design/chassis_power_limit_gain.sv =====
// ----------------------------------------------------------------------------
// chassis_power_limit_gain
// Chassis power-limit gain: capacitor/referee/tick bookkeeping and gain step.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Capacitor reports, referee
// reports and offline ticks go straight to the output register. A control
// step runs through a shared bit-serial divider and a bit-serial multiplier:
// the capacitor path takes one divide and the buffer path a multiply and a
// divide; under-voltage scaling adds one divide and two multiplies. The
// fallback gain, a capacitor charge at or below the floor, and a buffer
// below 10 J use neither unit unless scaling applies. The next transaction
// is taken once the result sits in the output register, so a stalled output
// holds off the next transaction.
module chassis_power_limit_gain (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [14:0]        cap_raw,
	input  logic [15:0]        max_current_raw,
	input  logic [15:0]        present_current_raw,
	input  logic signed [15:0] remain_buffer,
	input  logic               referee_offline,
	input  logic [1:0]         boost_level,
	input  logic               use_capacitor,
	input  logic               cap_healthy,
	input  logic               backup_request,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        limit_gain,
	output logic               module_online,
	output logic [15:0]        under_voltage_gain,
	output logic [14:0]        window_floor
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CAP_DIV, ST_BUF_MUL, ST_BUF_DIV, ST_UV,
		ST_UV_DIV, ST_MUL1, ST_MUL2, ST_DONE
	} state_t;

	state_t state_q;

	logic [14:0]        cap_q;
	logic [15:0]        maxc_q;
	logic [15:0]        presc_q;
	logic [8:0]         bufc_q;
	logic signed [15:0] bufraw_q;
	logic [14:0]        floor_q;
	logic [14:0]        range_q;
	logic [15:0]        ovf_q;
	logic [6:0]         decim_q;
	logic [1:0]         prevb_q;
	logic               backup_q;
	logic [7:0]         offcnt_q;
	logic               online_q;
	logic [15:0]        gain_q;
	logic [15:0]        uv_q;
	logic [15:0]        g_q;
	logic               out_valid_q;
	logic [15:0]        out_gain_q;
	logic               out_online_q;
	logic [15:0]        out_uv_q;
	logic [14:0]        out_floor_q;

	cplg_pkg::div_req_t div_req_q;
	cplg_pkg::mul_req_t mul_req_q;
	logic               div_done;
	logic               mul_done;
	logic [31:0]        quot;
	logic [31:0]        prod;

	cplg_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .done(div_done),
		.quotient(quot));
	cplg_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req_q), .done(mul_done),
		.product(prod));

	// window selection, capacitor-path test and buffer overflow-factor step
	logic               bk_eff;
	logic               bk_new;
	logic [14:0]        fl_new;
	logic [14:0]        rg_new;
	logic signed [16:0] cs;
	logic signed [16:0] cm3k;
	logic signed [16:0] cm900;
	logic signed [16:0] f1;
	logic signed [16:0] diff;
	logic               cap_path;
	logic [6:0]         dc;
	logic [15:0]        ovf_new;
	logic [15:0]        ovf_sub;

	always_comb begin
		bk_eff = backup_q | backup_request;
		bk_new = bk_eff;
		fl_new = floor_q;
		rg_new = range_q;
		cs     = $signed({2'b00, cap_q});
		cm3k   = cs - 17'sd3000;
		cm900  = cs - 17'sd900;
		f1     = $signed({2'b00, floor_q});
		if (boost_level == 2'd3) begin
			fl_new = 15'd9000;
			rg_new = 15'd6000;
		end else if (boost_level != 2'd0) begin
			if (bk_eff) begin
				fl_new = 15'd9000;
				rg_new = 15'd6000;
			end else if (boost_level == 2'd2) begin
				fl_new = 15'd15000;
				rg_new = 15'd3000;
			end else if (prevb_q == 2'd0) begin
				fl_new = (cm3k > 17'sd15000) ? cm3k[14:0] : 15'd15000;
				rg_new = 15'd3000;
			end
		end else begin
			if (prevb_q == 2'd1) begin
				if (cm900 < 17'sd15000) begin
					f1 = 17'sd15000;
				end else if (cm900 > 17'sd27000) begin
					f1 = 17'sd27000;
				end else begin
					f1 = cm900;
				end
			end
			if (bk_eff && cs < 17'sd16500) begin
				fl_new = 15'd9000;
				rg_new = 15'd6000;
			end else begin
				bk_new = 1'b0;
				rg_new = 15'd3000;
				if (cs >= 17'sd27900) begin
					fl_new = 15'd27000;
				end else if (cm3k < f1) begin
					fl_new = f1[14:0];
				end else if (cm3k > 17'sd27000) begin
					fl_new = 15'd27000;
				end else begin
					fl_new = cm3k[14:0];
				end
			end
		end
		diff     = cs - $signed({2'b00, fl_new});
		cap_path = online_q && cap_healthy && (use_capacitor || bufc_q >= 9'd40);
		dc       = (decim_q == 7'd100) ? 7'd0 : decim_q;
		ovf_sub  = ovf_q - cplg_pkg::Q_OVF_STEP;
		ovf_new  = ovf_q;
		if (dc == 7'd0 && bufraw_q <= 16'sd0) begin
			ovf_new = (ovf_sub < cplg_pkg::Q_OVF_MIN) ? cplg_pkg::Q_OVF_MIN : ovf_sub;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= '0;
			maxc_q      <= '0;
			presc_q     <= '0;
			bufc_q      <= '0;
			bufraw_q    <= '0;
			floor_q     <= 15'd9000;
			range_q     <= 15'd3000;
			ovf_q       <= cplg_pkg::Q_ONE;
			decim_q     <= '0;
			prevb_q     <= '0;
			backup_q    <= 1'b0;
			offcnt_q    <= 8'(cplg_pkg::OfflineTicks);
			online_q    <= 1'b0;
			gain_q      <= '0;
			uv_q        <= cplg_pkg::Q_ONE;
			g_q         <= '0;
			out_valid_q <= 1'b0;
			div_req_q   <= '0;
			mul_req_q   <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			mul_req_q.start <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DONE;
						case (req_type)
							cplg_pkg::REQ_CAP: begin
								cap_q    <= cap_raw;
								maxc_q   <= max_current_raw;
								presc_q  <= present_current_raw;
								offcnt_q <= '0;
							end
							cplg_pkg::REQ_REFEREE: begin
								bufraw_q <= remain_buffer;
								if (remain_buffer < 16'sd0) begin
									bufc_q <= '0;
								end else if (remain_buffer > 16'sd300) begin
									bufc_q <= 9'd300;
								end else begin
									bufc_q <= remain_buffer[8:0];
								end
							end
							cplg_pkg::REQ_TICK: begin
								if (offcnt_q < 8'(cplg_pkg::OfflineTicks)) begin
									offcnt_q <= offcnt_q + 8'd1;
									online_q <= 1'b1;
								end else begin
									online_q <= 1'b0;
								end
							end
							default: begin
								backup_q <= bk_eff;
								if (cap_path) begin
									backup_q <= bk_new;
									floor_q  <= fl_new;
									range_q  <= rg_new;
									prevb_q  <= boost_level;
									if (diff <= 17'sd0) begin
										g_q     <= cplg_pkg::Q_CAP_MIN;
										state_q <= ST_UV;
									end else begin
										div_req_q <= '{1'b1, {2'b00, diff[14:0], 15'd0},
											{1'b0, rg_new}};
										state_q   <= ST_CAP_DIV;
									end
								end else if (!referee_offline) begin
									decim_q <= dc + 7'd1;
									ovf_q   <= ovf_new;
									if (bufc_q < 9'd10) begin
										g_q     <= '0;
										state_q <= ST_UV;
									end else begin
										mul_req_q <= '{1'b1, {7'd0, bufc_q - 9'd10}, ovf_new};
										state_q   <= ST_BUF_MUL;
									end
								end else begin
									g_q     <= cplg_pkg::Q_FALLBACK;
									state_q <= ST_UV;
								end
							end
						endcase
					end
				end
				ST_CAP_DIV: begin
					if (div_done) begin
						if (quot > {16'd0, cplg_pkg::Q_ONE}) begin
							g_q <= cplg_pkg::Q_ONE;
						end else if (quot < {16'd0, cplg_pkg::Q_CAP_MIN}) begin
							g_q <= cplg_pkg::Q_CAP_MIN;
						end else begin
							g_q <= quot[15:0];
						end
						state_q <= ST_UV;
					end
				end
				ST_BUF_MUL: begin
					if (mul_done) begin
						div_req_q <= '{1'b1, prod, 16'd50};
						state_q   <= ST_BUF_DIV;
					end
				end
				ST_BUF_DIV: begin
					if (div_done) begin
						g_q <= (quot > {16'd0, cplg_pkg::Q_BUF_MAX}) ?
							cplg_pkg::Q_BUF_MAX : quot[15:0];
						state_q <= ST_UV;
					end
				end
				ST_UV: begin
					if (online_q && presc_q != 16'd0) begin
						div_req_q <= '{1'b1, {1'b0, maxc_q, 15'd0}, presc_q};
						state_q   <= ST_UV_DIV;
					end else begin
						gain_q  <= g_q;
						state_q <= ST_DONE;
					end
				end
				ST_UV_DIV: begin
					if (div_done) begin
						if (quot > {16'd0, cplg_pkg::Q_ONE}) begin
							uv_q            <= cplg_pkg::Q_ONE;
							mul_req_q       <= '{1'b1, g_q, cplg_pkg::Q_ONE};
						end else begin
							uv_q            <= quot[15:0];
							mul_req_q       <= '{1'b1, g_q, quot[15:0]};
						end
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (mul_done) begin
						mul_req_q <= '{1'b1, prod[30:15], uv_q};
						state_q   <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (mul_done) begin
						gain_q  <= prod[30:15];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_gain_q   <= gain_q;
			out_online_q <= online_q;
			out_uv_q     <= uv_q;
			out_floor_q  <= floor_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign limit_gain         = out_gain_q;
	assign module_online      = out_online_q;
	assign under_voltage_gain = out_uv_q;
	assign window_floor       = out_floor_q;

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= cplg_pkg::Q_ONE && uv_q <= cplg_pkg::Q_ONE)
		else $error("gain register above one");

	a_unit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_req_q.start && mul_req_q.start))
		else $error("divider and multiplier started together");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted transaction did not leave idle");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!out_valid_q || out_ready) |=> out_valid_q)
		else $error("result not presented");

endmodule

// ===== sim/tb_chassis_power_limit_gain.sv =====
// ----------------------------------------------------------------------------
// tb_chassis_power_limit_gain
// Self-checking testbench of the chassis power-limit gain block: a predictor
// tracks the block state per transaction, a driver and a monitor apply random
// gaps, a long output hold-off and drain pauses; every result is compared.
// ----------------------------------------------------------------------------
module tb_chassis_power_limit_gain;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]         kind;
		logic [14:0]        cap;
		logic [15:0]        imax;
		logic [15:0]        inow;
		logic signed [15:0] buf_e;
		logic               ref_off;
		logic [1:0]         boost;
		logic               use_cap;
		logic               healthy;
		logic               backup;
		logic               drain;
	} gain_req_t;

	typedef struct {
		logic [15:0] gain;
		logic        online;
		logic [15:0] uv;
		logic [14:0] floor_lvl;
	} gain_res_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [1:0] req_type = cplg_pkg::REQ_CAP;
	logic [14:0] cap_raw = 0;
	logic [15:0] max_current_raw = 0, present_current_raw = 0;
	logic signed [15:0] remain_buffer = 0;
	logic referee_offline = 0, use_capacitor = 0, cap_healthy = 0, backup_request = 0;
	logic [1:0] boost_level = 0;
	logic [15:0] limit_gain, under_voltage_gain;
	logic module_online;
	logic [14:0] window_floor;

	chassis_power_limit_gain DUT (.*);

	always #6 clk = ~clk;

	gain_req_t pending_reqs[$];
	gain_res_t expected_results[$];
	int errors = 0, rx_count = 0, tx_count = 0, n_ctrl = 0, n_cap_path = 0;
	int cycles = 0;

	// predictor state
	int st_cap, st_imax, st_inow, st_bufc, st_bufr, st_floor, st_range;
	longint st_ovf, st_gain, st_uv;
	int st_decim, st_prev_boost, st_offcnt;
	bit st_backup, st_online;

	function automatic int clampi(int x, int lo, int hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic void reset_state();
		st_cap = 0; st_imax = 0; st_inow = 0; st_bufc = 0; st_bufr = 0;
		st_floor = 9000; st_range = 3000; st_ovf = cplg_pkg::Q_ONE; st_decim = 0;
		st_prev_boost = 0; st_backup = 0; st_offcnt = cplg_pkg::OfflineTicks;
		st_gain = 0; st_uv = cplg_pkg::Q_ONE; st_online = 0;
	endfunction

	function automatic void set_win(int lo, int hi);
		st_floor = lo;
		st_range = hi - lo;
	endfunction

	function automatic void update_window(int b);
		int c;
		c = st_cap;
		if (b == 3) begin
			set_win(9000, 15000);
		end else if (b != 0) begin
			if (st_backup) set_win(9000, 15000);
			else if (b == 2) set_win(15000, 18000);
			else if (st_prev_boost == 0) begin
				st_floor = (c - 3000 > 15000) ? c - 3000 : 15000;
				st_range = 3000;
			end
		end else begin
			if (st_prev_boost == 1) st_floor = clampi(c - 900, 15000, 27000);
			if (st_backup && c < 16500) begin
				set_win(9000, 15000);
			end else begin
				st_backup = 0;
				if (c >= 27900) set_win(27000, 30000);
				else begin
					st_floor = clampi(c - 3000, st_floor, 27000);
					st_range = 3000;
				end
			end
		end
		st_prev_boost = b;
	endfunction

	function automatic gain_res_t predict_gain(gain_req_t r);
		gain_res_t res;
		longint g, d, u;
		int c;
		case (r.kind)
			cplg_pkg::REQ_CAP: begin
				st_cap = r.cap; st_imax = r.imax; st_inow = r.inow; st_offcnt = 0;
			end
			cplg_pkg::REQ_REFEREE: begin
				st_bufr = r.buf_e;
				st_bufc = clampi(st_bufr, 0, 300);
			end
			cplg_pkg::REQ_TICK: begin
				if (st_offcnt < cplg_pkg::OfflineTicks) begin
					st_offcnt++;
					st_online = 1;
				end else st_online = 0;
			end
			default: begin
				n_ctrl++;
				if (r.backup) st_backup = 1;
				if (st_online && r.healthy && (r.use_cap || st_bufc >= 40)) begin
					n_cap_path++;
					update_window(r.boost);
					d = longint'(st_cap) - st_floor;
					if (d <= 0 || st_range <= 0) g = cplg_pkg::Q_CAP_MIN;
					else g = (d * cplg_pkg::Q_ONE) / st_range;
					if (g < cplg_pkg::Q_CAP_MIN) g = cplg_pkg::Q_CAP_MIN;
					if (g > cplg_pkg::Q_ONE) g = cplg_pkg::Q_ONE;
				end else if (!r.ref_off) begin
					c = st_decim % 100;
					st_decim = c + 1;
					if (c == 0 && st_bufr <= 0) begin
						st_ovf -= cplg_pkg::Q_OVF_STEP;
						if (st_ovf < cplg_pkg::Q_OVF_MIN) st_ovf = cplg_pkg::Q_OVF_MIN;
						if (st_ovf > cplg_pkg::Q_ONE) st_ovf = cplg_pkg::Q_ONE;
					end
					g = (longint'(st_bufc - 10) * st_ovf) / 50;
					if (g < 0) g = 0;
					if (g > cplg_pkg::Q_BUF_MAX) g = cplg_pkg::Q_BUF_MAX;
				end else g = cplg_pkg::Q_FALLBACK;
				if (st_online && st_inow != 0) begin
					u = (longint'(st_imax) * cplg_pkg::Q_ONE) / st_inow;
					if (u > cplg_pkg::Q_ONE) u = cplg_pkg::Q_ONE;
					st_uv = u;
					g = (g * u) >>> cplg_pkg::GainFracBits;
					g = (g * u) >>> cplg_pkg::GainFracBits;
				end
				st_gain = g;
			end
		endcase
		res.gain = st_gain[15:0];
		res.online = st_online;
		res.uv = st_uv[15:0];
		res.floor_lvl = st_floor[14:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("MISMATCH result %0d %s: got %0d expected %0d", rx_count, what, got, want);
	endtask

	function automatic gain_req_t make_req(logic [1:0] k);
		gain_req_t r;
		r.kind = k;
		r.cap = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 30000));
		r.inow = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20000));
		r.imax = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 22000));
		if ($urandom_range(0, 5) == 0) r.inow = '0;
		r.buf_e = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 330) - 20);
		r.ref_off = ($urandom_range(0, 4) == 0);
		r.boost = 2'($urandom);
		r.use_cap = 1'($urandom);
		r.healthy = ($urandom_range(0, 5) != 0);
		r.backup = ($urandom_range(0, 6) == 0);
		r.drain = 1'b0;
		return r;
	endfunction

	// driver
	int tx_gap = 0;
	bit in_acc = 0;
	always @(posedge clk) begin
		in_acc <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			expected_results.push_back(predict_gain(gain_req_t'{req_type, cap_raw,
				max_current_raw, present_current_raw, remain_buffer, referee_offline,
				boost_level, use_capacitor, cap_healthy, backup_request, 1'b0}));
			tx_count++;
		end
	end

	always @(negedge clk) begin
		gain_req_t r;
		if (arst_n && !(in_valid && !in_acc)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 0;
			end else if (pending_reqs.size() > 0 &&
					(!pending_reqs[0].drain || expected_results.size() == 0)) begin
				r = pending_reqs.pop_front();
				req_type <= r.kind; cap_raw <= r.cap; max_current_raw <= r.imax;
				present_current_raw <= r.inow; remain_buffer <= r.buf_e;
				referee_offline <= r.ref_off; boost_level <= r.boost;
				use_capacitor <= r.use_cap; cap_healthy <= r.healthy;
				backup_request <= r.backup;
				in_valid <= 1;
				tx_gap = ((tx_count / 150) % 3 == 0) ? 0 : $urandom_range(0, 15);
			end else in_valid <= 0;
		end
	end

	// monitor
	int rx_gap = 0, hold_cnt = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		gain_res_t e;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("MISMATCH unexpected result %0d", rx_count);
			end else begin
				e = expected_results.pop_front();
				if (limit_gain !== e.gain) report_mismatch("limit_gain", limit_gain, e.gain);
				if (module_online !== e.online)
					report_mismatch("module_online", module_online, e.online);
				if (under_voltage_gain !== e.uv)
					report_mismatch("under_voltage_gain", under_voltage_gain, e.uv);
				if (window_floor !== e.floor_lvl)
					report_mismatch("window_floor", window_floor, e.floor_lvl);
			end
			rx_count++;
			rx_gap <= ((rx_count / 170) % 3 == 1) ? 0 : $urandom_range(0, 15);
		end else if (rx_gap > 0) rx_gap <= rx_gap - 1;
	end

	always @(posedge clk) begin
		if (rx_count == 400 && !hold_done) begin
			hold_done <= 1;
			hold_cnt <= 500;
		end else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
	end

	always @(negedge clk) begin
		if (!arst_n) out_ready <= 0;
		else if (hold_cnt > 0) out_ready <= 0;
		else if (rx_gap > 0) out_ready <= 0;
		else out_ready <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("chassis_power_limit_gain verification failed");
			$finish;
		end
	end

	initial begin
		gain_req_t r;
		int n;
		reset_state();
		// directed
		r = make_req(cplg_pkg::REQ_TICK); pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CONTROL); r.ref_off = 0; pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CONTROL); r.ref_off = 1; pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_REFEREE); r.buf_e = 16'sh7fff; pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_REFEREE); r.buf_e = 16'sh8000; pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CAP); r.cap = 15'h7fff; r.imax = 16'hffff;
		r.inow = 16'hffff;
		pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_TICK); pending_reqs.push_back(r);
		for (int b = 0; b < 4; b++) begin
			r = make_req(cplg_pkg::REQ_CONTROL); r.boost = 2'(b); r.healthy = 1;
			r.use_cap = 1; r.backup = (b == 1); pending_reqs.push_back(r);
		end
		r = make_req(cplg_pkg::REQ_CAP); r.cap = '0; r.imax = '0; r.inow = '0;
		pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CONTROL); r.healthy = 1; r.use_cap = 1; r.boost = 2'd0;
		pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CAP); r.cap = 15'd29000; r.imax = 16'd100;
		r.inow = 16'hffff;
		pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CONTROL); r.healthy = 1; r.use_cap = 0; r.boost = 2'd1;
		pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_REFEREE); r.buf_e = 16'sd300; pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CONTROL); r.healthy = 1; r.use_cap = 0; r.boost = 2'd0;
		pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CONTROL); r.healthy = 0; r.ref_off = 0;
		pending_reqs.push_back(r);
		r = make_req(cplg_pkg::REQ_CONTROL); r.healthy = 0; r.ref_off = 1; r.drain = 1;
		pending_reqs.push_back(r);
		// random: mostly report/tick/control frames
		n = pending_reqs.size();
		while (n < 1300) begin
			if (n > 700 && n < 720) begin
				for (int i = 0; i < 255; i++)
					pending_reqs.push_back(make_req(cplg_pkg::REQ_TICK));
				n += 255;
			end
			if ($urandom_range(0, 4) == 0) begin
				pending_reqs.push_back(make_req(2'($urandom)));
				n++;
			end else begin
				if ($urandom_range(0, 2) != 0) begin
					pending_reqs.push_back(make_req(cplg_pkg::REQ_CAP)); n++;
				end
				if ($urandom_range(0, 1)) begin
					pending_reqs.push_back(make_req(cplg_pkg::REQ_REFEREE)); n++;
				end
				pending_reqs.push_back(make_req(cplg_pkg::REQ_TICK)); n++;
				for (int i = $urandom_range(1, 4); i > 0; i--) begin
					r = make_req(cplg_pkg::REQ_CONTROL);
					r.drain = ($urandom_range(0, 150) == 0);
					pending_reqs.push_back(r); n++;
				end
			end
		end
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (150) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("MISMATCH %0d results never arrived", expected_results.size());
		end
		$display("%0d transactions checked, %0d control steps (%0d on the capacitor path)",
			rx_count, n_ctrl, n_cap_path);
		if (errors == 0) $display("chassis_power_limit_gain verification clean");
		else $display("chassis_power_limit_gain verification failed");
		$finish;
	end
endmodule

// ===== chassis_power_limit_gain.f =====
design/cplg_pkg.sv
design/cplg_div.sv
design/cplg_mul.sv
design/chassis_power_limit_gain.sv
sim/tb_chassis_power_limit_gain.sv
